/* sv/stwg_pkg.sv */
// Shared types, constants and the word recursion of the SIMD twister word generator.
// Used by the top level, its port checker and the testbench; depends on nothing else.
package stwg_pkg;

  // Ring geometry.
  localparam int STATE_WORDS = 156;
  localparam int LANES       = 4 * STATE_WORDS;
  localparam int WIDX_W      = $clog2(STATE_WORDS);
  localparam int LANE_W      = WIDX_W + 2;
  localparam int PTR_W       = $clog2(LANES + 1);

  // Width of the middle-word offset register and of the index sum built from it.
  localparam int OFF_W = 8;
  localparam int SUM_W = ((WIDX_W > OFF_W) ? WIDX_W : OFF_W) + 1;

  localparam logic [31:0] SEED_MULT = 32'd1812433253;

  // Configuration register reset values.
  localparam logic [7:0] POS1_RESET = 8'd71;
  localparam logic [4:0] SL1_RESET  = 5'd11;
  localparam logic [4:0] SL2_RESET  = 5'd7;
  localparam logic [4:0] SR1_RESET  = 5'd17;

  typedef logic [127:0] word_t;
  typedef logic [31:0]  lane_t;

  typedef enum logic [1:0] {
    REG_POS1,
    REG_SL1,
    REG_SL2,
    REG_SR1
  } cfg_reg_t;

  typedef enum logic {
    KIND_SEED,
    KIND_DRAW
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_MOD,
    S_PRE,
    S_PREW,
    S_RRD,
    S_RCALC,
    S_DRAW_RD,
    S_DRAW_WAIT
  } state_t;

  // Regenerates one word from the current, middle and previous words.
  function automatic word_t recur_word(word_t c, word_t m, word_t p,
                                       logic [4:0] sl1, logic [4:0] sl2,
                                       logic [4:0] sr1);
    word_t r;
    lane_t ck;
    lane_t mk;
    lane_t pk;
    lane_t v;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      ck = c[k*32 +: 32];
      mk = m[k*32 +: 32];
      pk = p[k*32 +: 32];
      v  = (ck << sl1) ^ ck ^ (mk >> sr1) ^ (pk << sl2);
      if (k < 3) begin
        v = v ^ m[(k+1)*32 +: 32];
      end
      if (k > 0) begin
        v = v ^ p[(k-1)*32 +: 32];
      end
      r[k*32 +: 32] = v;
    end
    return r;
  endfunction

endpackage

/* sv/simd_twister_word_generator_top.sv */
// Top level of the SIMD twister word generator: sequencer, state ring memory and output register.
// Depends on stwg_pkg for geometry, codes and the word recursion.
//
// The generator keeps a ring of 156 words of 128 bits, four 32-bit lanes each, in a memory
// with one write port and two registered read ports. A seed transaction (kind 0) fills every
// lane with the multiply chain from the seed, one lane per cycle through a single 32x32
// multiplier, so it occupies the block until the last lane is written and gives no result.
// A draw transaction (kind 1) returns the next lane: the lane is read through a registered
// memory read port and then loaded into the output register once that register is free.
// When every lane has been used, the draw first regenerates the ring in place through one shared
// recursion unit, word by word, after reducing the middle-word offset. The input is not
// ready while a transaction is in progress, but a new transaction is accepted while a result
// still waits in the output register. A per-word valid bit, cleared by reset, makes any word
// never written since reset read as zero, so no clearing pass is needed. Configuration
// registers may be written at any time the block is idle.
module simd_twister_word_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [31:0] seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_word,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Control registers.
  stwg_pkg::state_t                state, state_next;
  logic [stwg_pkg::PTR_W-1:0]      read_ptr, read_ptr_next;
  logic                            out_valid_r, out_valid_next;

  // Configuration registers.
  logic [7:0] pos1;
  logic [4:0] sl1;
  logic [4:0] sl2;
  logic [4:0] sr1;

  // Datapath registers.
  logic [stwg_pkg::WIDX_W-1:0]     idx, idx_next;
  logic [stwg_pkg::LANE_W-1:0]     lane_cnt, lane_cnt_next;
  logic [stwg_pkg::OFF_W-1:0]      mid_off, mid_off_next;
  stwg_pkg::lane_t                 prev_lane, prev_lane_next;
  logic [95:0]                     word_buf, word_buf_next;
  stwg_pkg::word_t                 prev_word, prev_word_next;
  stwg_pkg::lane_t                 out_word, out_word_next;

  // Memory, its valid bits and its read ports.
  stwg_pkg::word_t                 mem [stwg_pkg::STATE_WORDS];
  logic [stwg_pkg::STATE_WORDS-1:0] row_valid;
  logic                            wr_en;
  logic [stwg_pkg::WIDX_W-1:0]     wr_addr;
  stwg_pkg::word_t                 wr_data;
  logic                            rd_en;
  logic [stwg_pkg::WIDX_W-1:0]     rd_a_addr, rd_b_addr;
  stwg_pkg::word_t                 rd_a, rd_b;
  logic                            rd_a_ok, rd_b_ok;

  // Combinational helpers.
  stwg_pkg::word_t                 cur_word, mid_word, new_word;
  stwg_pkg::lane_t                 seed_lane;
  logic [stwg_pkg::SUM_W-1:0]      off_ext, mid_sum;
  logic [stwg_pkg::WIDX_W-1:0]     mid_idx;
  logic                            accept;

  assign in_ready    = (state == stwg_pkg::S_IDLE);
  assign accept      = in_valid && in_ready;
  assign out_valid   = out_valid_r;
  assign random_word = out_word;

  // Words never written since reset read as zero.
  assign cur_word = rd_a_ok ? rd_a : '0;
  assign mid_word = rd_b_ok ? rd_b : '0;
  assign new_word = stwg_pkg::recur_word(cur_word, mid_word, prev_word, sl1, sl2, sr1);

  // One step of the seeding chain: the shared multiplier.
  assign seed_lane = stwg_pkg::SEED_MULT * (prev_lane ^ (prev_lane >> 30))
                   + {{(32 - stwg_pkg::LANE_W){1'b0}}, lane_cnt};

  // Index of the middle word, wrapped round the ring.
  assign off_ext = stwg_pkg::SUM_W'(mid_off);
  always_comb begin
    mid_sum = stwg_pkg::SUM_W'(idx) + off_ext;
    if (mid_sum >= stwg_pkg::SUM_W'(stwg_pkg::STATE_WORDS)) begin
      mid_sum = mid_sum - stwg_pkg::SUM_W'(stwg_pkg::STATE_WORDS);
    end
    mid_idx = mid_sum[stwg_pkg::WIDX_W-1:0];
  end

  // Sequencer: next state, datapath next values and memory controls.
  always_comb begin
    state_next     = state;
    read_ptr_next  = read_ptr;
    out_valid_next = out_valid_r && !out_ready;
    idx_next       = idx;
    lane_cnt_next  = lane_cnt;
    mid_off_next   = mid_off;
    prev_lane_next = prev_lane;
    word_buf_next  = word_buf;
    prev_word_next = prev_word;
    out_word_next  = out_word;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = new_word;
    rd_en          = 1'b0;
    rd_a_addr      = idx;
    rd_b_addr      = mid_idx;

    unique case (state)
      stwg_pkg::S_IDLE: begin
        if (accept) begin
          if (stwg_pkg::kind_t'(kind) == stwg_pkg::KIND_SEED) begin
            prev_lane_next      = seed;
            word_buf_next[31:0] = seed;
            lane_cnt_next       = stwg_pkg::LANE_W'(1);
            state_next          = stwg_pkg::S_SEED;
          end else if (read_ptr >= stwg_pkg::PTR_W'(stwg_pkg::LANES)) begin
            mid_off_next = pos1;
            state_next   = stwg_pkg::S_MOD;
          end else begin
            state_next = stwg_pkg::S_DRAW_RD;
          end
        end
      end

      stwg_pkg::S_SEED: begin
        prev_lane_next = seed_lane;
        case (lane_cnt[1:0])
          2'd0: word_buf_next[31:0]  = seed_lane;
          2'd1: word_buf_next[63:32] = seed_lane;
          2'd2: word_buf_next[95:64] = seed_lane;
          default: begin
            // Last lane of a word completes it.
            wr_en   = 1'b1;
            wr_addr = lane_cnt[stwg_pkg::LANE_W-1:2];
            wr_data = {seed_lane, word_buf};
          end
        endcase
        if (lane_cnt == stwg_pkg::LANE_W'(stwg_pkg::LANES - 1)) begin
          read_ptr_next = stwg_pkg::PTR_W'(stwg_pkg::LANES);
          state_next    = stwg_pkg::S_IDLE;
        end else begin
          lane_cnt_next = lane_cnt + 1'b1;
        end
      end

      stwg_pkg::S_MOD: begin
        // Bring the middle-word distance below the ring size.
        if (off_ext >= stwg_pkg::SUM_W'(stwg_pkg::STATE_WORDS)) begin
          mid_off_next = stwg_pkg::OFF_W'(off_ext - stwg_pkg::SUM_W'(stwg_pkg::STATE_WORDS));
        end else begin
          state_next = stwg_pkg::S_PRE;
        end
      end

      stwg_pkg::S_PRE: begin
        // The last word is the previous word of word 0.
        rd_en      = 1'b1;
        rd_a_addr  = stwg_pkg::WIDX_W'(stwg_pkg::STATE_WORDS - 1);
        state_next = stwg_pkg::S_PREW;
      end

      stwg_pkg::S_PREW: begin
        prev_word_next = cur_word;
        idx_next       = '0;
        state_next     = stwg_pkg::S_RRD;
      end

      stwg_pkg::S_RRD: begin
        rd_en      = 1'b1;
        state_next = stwg_pkg::S_RCALC;
      end

      stwg_pkg::S_RCALC: begin
        wr_en          = 1'b1;
        prev_word_next = new_word;
        if (idx == stwg_pkg::WIDX_W'(stwg_pkg::STATE_WORDS - 1)) begin
          read_ptr_next = '0;
          state_next    = stwg_pkg::S_DRAW_RD;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = stwg_pkg::S_RRD;
        end
      end

      stwg_pkg::S_DRAW_RD: begin
        rd_en      = 1'b1;
        rd_a_addr  = read_ptr[stwg_pkg::WIDX_W+1:2];
        state_next = stwg_pkg::S_DRAW_WAIT;
      end

      stwg_pkg::S_DRAW_WAIT: begin
        if (!out_valid_r || out_ready) begin
          case (read_ptr[1:0])
            2'd0:    out_word_next = cur_word[31:0];
            2'd1:    out_word_next = cur_word[63:32];
            2'd2:    out_word_next = cur_word[95:64];
            default: out_word_next = cur_word[127:96];
          endcase
          out_valid_next = 1'b1;
          read_ptr_next  = read_ptr + 1'b1;
          state_next     = stwg_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = stwg_pkg::S_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= stwg_pkg::S_IDLE;
      read_ptr    <= '0;
      out_valid_r <= 1'b0;
      pos1        <= stwg_pkg::POS1_RESET;
      sl1         <= stwg_pkg::SL1_RESET;
      sl2         <= stwg_pkg::SL2_RESET;
      sr1         <= stwg_pkg::SR1_RESET;
    end else begin
      state       <= state_next;
      read_ptr    <= read_ptr_next;
      out_valid_r <= out_valid_next;
      if (cfg_write) begin
        unique case (stwg_pkg::cfg_reg_t'(cfg_index))
          stwg_pkg::REG_POS1: pos1 <= cfg_data;
          stwg_pkg::REG_SL1:  sl1  <= cfg_data[4:0];
          stwg_pkg::REG_SL2:  sl2  <= cfg_data[4:0];
          stwg_pkg::REG_SR1:  sr1  <= cfg_data[4:0];
        endcase
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    lane_cnt  <= lane_cnt_next;
    mid_off   <= mid_off_next;
    prev_lane <= prev_lane_next;
    word_buf  <= word_buf_next;
    prev_word <= prev_word_next;
    out_word  <= out_word_next;
  end

  // Valid bit per word: cleared by reset, set on every write.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // State ring memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a    <= mem[rd_a_addr];
      rd_a_ok <= row_valid[rd_a_addr];
      rd_b    <= mem[rd_b_addr];
      rd_b_ok <= row_valid[rd_b_addr];
    end
  end

endmodule

/* sv/stwg_checker.sv */
// Port-level checker for the SIMD twister word generator, with its bind to the top level.
// Depends on stwg_pkg for the input kind codes.
module stwg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] random_word
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(random_word))
    else $error("stalled result changed or was dropped");

  // The input is not ready in the cycle after every transaction the block takes.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted transaction");

  // A seed gives no result.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (stwg_pkg::kind_t'(kind) == stwg_pkg::KIND_SEED) && !out_valid
    |=> !out_valid)
    else $error("result appeared after a seed transaction");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind simd_twister_word_generator_top stwg_checker u_stwg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .random_word (random_word)
);

/* tb/tb_simd_twister_word_generator_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for simd_twister_word_generator_top: directed and random seed and draw
// transactions, a lane-exact predictor of the word ring, and a result checker.
// Depends on stwg_pkg and the generator RTL only.
module tb_simd_twister_word_generator_top;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 10;
  // A seed transaction keeps the block busy with nothing to show for it, so before touching
  // the registers we let SETTLE_CYCLES pass after the last result, longer than a seed takes.
  localparam int SETTLE_CYCLES = 800;
  localparam int LONG_HOLD     = 1200;
  localparam int LIMIT_CYCLES  = 1500000;
  localparam int PHASES        = 8;
  localparam int LONG_RUN      = 640;
  localparam int PHASE_ITEMS   = 42;
  localparam int REPORT_MAX    = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    stwg_pkg::kind_t op;
    stwg_pkg::lane_t value;
  } gen_item_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic        kind        = 1'b0;
  logic [31:0] seed        = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [31:0] random_word;
  logic        cfg_write   = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [7:0]  cfg_data    = '0;

  // Stimulus waiting to be offered, and lanes the generator still owes us.
  gen_item_t         pending_q[$];
  stwg_pkg::lane_t   lane_expect_q[$];

  idle_mode_t  idle_mode     = IDLE_NONE;
  int          hold_requests = 0;
  int          holds_served  = 0;
  int          hold_left     = 0;
  int          mismatch_count = 0;
  int          cycle_count   = 0;

  // Predictor state: our own copy of the ring, the lane pointer and the four registers.
  stwg_pkg::lane_t model_ring [stwg_pkg::STATE_WORDS][4];
  int          lane_ptr;
  logic [7:0]  mid_dist;
  logic [4:0]  cur_shl;
  logic [4:0]  prev_shl;
  logic [4:0]  mid_shr;

  simd_twister_word_generator_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .seed        (seed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_word (random_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Seeding fills every lane of the ring with the multiply chain and parks the pointer at the
  // end, so the very next draw triggers a full regeneration.
  function automatic void reseed_ring(stwg_pkg::lane_t start);
    stwg_pkg::lane_t prev;
    stwg_pkg::lane_t nxt;
    prev = start;
    model_ring[0][0] = start;
    for (int i = 1; i < stwg_pkg::LANES; i++) begin
      nxt = stwg_pkg::SEED_MULT * (prev ^ (prev >> 30)) + stwg_pkg::lane_t'(i);
      model_ring[i / 4][i % 4] = nxt;
      prev = nxt;
    end
    lane_ptr = stwg_pkg::LANES;
  endfunction

  // Regeneration works lane by lane on the live ring. Every read sees whatever is stored at
  // that instant, so the previous word is already new (except for word 0, which sees the old
  // last word), and when the middle word is the current one its higher lanes are still old.
  function automatic void rebuild_ring();
    int              mw;
    int              pw;
    stwg_pkg::lane_t cur;
    stwg_pkg::lane_t v;
    for (int w = 0; w < stwg_pkg::STATE_WORDS; w++) begin
      mw = (w + (int'(mid_dist) % stwg_pkg::STATE_WORDS)) % stwg_pkg::STATE_WORDS;
      pw = (w + stwg_pkg::STATE_WORDS - 1) % stwg_pkg::STATE_WORDS;
      for (int k = 0; k < 4; k++) begin
        cur = model_ring[w][k];
        v = (cur << cur_shl) ^ cur ^ (model_ring[mw][k] >> mid_shr)
            ^ (model_ring[pw][k] << prev_shl);
        if (k < 3) begin
          v = v ^ model_ring[mw][k + 1];
        end
        if (k > 0) begin
          v = v ^ model_ring[pw][k - 1];
        end
        model_ring[w][k] = v;
      end
    end
  endfunction

  // Applies one accepted transaction to the predictor; a draw queues the lane it must return.
  function automatic void predict_transaction(stwg_pkg::kind_t op, stwg_pkg::lane_t value);
    if (op == stwg_pkg::KIND_SEED) begin
      reseed_ring(value);
    end else begin
      if (lane_ptr >= stwg_pkg::LANES) begin
        rebuild_ring();
        lane_ptr = 0;
      end
      lane_expect_q.push_back(model_ring[lane_ptr / 4][lane_ptr % 4]);
      lane_ptr++;
    end
  endfunction

  // Input driver. A transaction completes at an edge where valid and ready are both high; the
  // next item, if any and if the sender is not idling this cycle, is offered at the same edge.
  always @(posedge clk) begin : drive_inputs
    gen_item_t nxt;
    int        idle_pct;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_transaction(stwg_pkg::kind_t'(kind), seed);
      end
      if (!in_valid || in_ready) begin
        case (idle_mode)
          IDLE_SENDER: idle_pct = 66;
          IDLE_BOTH:   idle_pct = 34;
          default:     idle_pct = 0;
        endcase
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_q.pop_front();
          in_valid <= 1'b1;
          kind     <= nxt.op;
          seed     <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output ready. A request for a long hold-off is served here and counted down in cycles, so
  // that the output register fills, the block stalls and its input stops accepting.
  always @(posedge clk) begin : drive_ready
    int stall_pct;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= LONG_HOLD;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: stall_pct = 66;
        IDLE_BOTH:     stall_pct = 34;
        default:       stall_pct = 0;
      endcase
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: every completed output transaction must match the oldest owed lane.
  always @(posedge clk) begin : check_results
    stwg_pkg::lane_t want;
    if (!rst && out_valid && out_ready) begin
      if (lane_expect_q.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < REPORT_MAX) begin
          $display("[%0t] unexpected random_word %h with nothing owed", $realtime, random_word);
        end
      end else begin
        want = lane_expect_q.pop_front();
        if (random_word !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < REPORT_MAX) begin
            $display("[%0t] random_word mismatch: expected %h, got %h",
                     $realtime, want, random_word);
          end
        end
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void queue_item(stwg_pkg::kind_t op, stwg_pkg::lane_t value);
    gen_item_t it;
    it.op    = op;
    it.value = value;
    pending_q.push_back(it);
  endfunction

  // Waits until the sender has nothing left, every owed lane has arrived, and a possible
  // trailing seed transaction has had time to finish.
  task automatic wait_quiet();
    while (pending_q.size() != 0 || in_valid || lane_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(stwg_pkg::cfg_reg_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      stwg_pkg::REG_POS1: mid_dist = value;
      stwg_pkg::REG_SL1:  cur_shl  = value[4:0];
      stwg_pkg::REG_SL2:  prev_shl = value[4:0];
      stwg_pkg::REG_SR1:  mid_shr  = value[4:0];
      default: ;
    endcase
  endtask

  // Random phase content: a seed and a short run of draws, which exercises the regeneration
  // straight away, then further runs, mostly carrying on from the pointer, some after a seed.
  task automatic queue_phase(int n_items);
    int              count;
    int              run;
    stwg_pkg::lane_t s;
    count = 0;
    while (count < n_items) begin
      if (count == 0 || $urandom_range(3) == 0) begin
        case ($urandom_range(7))
          0:       s = '0;
          1:       s = '1;
          default: s = $urandom;
        endcase
        queue_item(stwg_pkg::KIND_SEED, s);
        count++;
      end
      run = $urandom_range(1, 12);
      for (int i = 0; i < run; i++) begin
        queue_item(stwg_pkg::KIND_DRAW, $urandom);
      end
      count += run;
    end
  endtask

  initial begin : run_test
    logic [7:0] set_pos1 [PHASES];
    logic [7:0] set_sl1  [PHASES];
    logic [7:0] set_sl2  [PHASES];
    logic [7:0] set_sr1  [PHASES];

    foreach (model_ring[w, k]) begin
      model_ring[w][k] = '0;
    end
    lane_ptr = 0;
    mid_dist = stwg_pkg::POS1_RESET;
    cur_shl  = stwg_pkg::SL1_RESET;
    prev_shl = stwg_pkg::SL2_RESET;
    mid_shr  = stwg_pkg::SR1_RESET;

    // Register settings per phase: reset values, all zero (middle word is the current word),
    // the largest in-range offset with maximal shifts, offsets at and beyond the ring size,
    // two random mixes with the upper data bits set at random, and back to the defaults.
    set_pos1[0] = stwg_pkg::POS1_RESET; set_sl1[0] = 8'(stwg_pkg::SL1_RESET);
    set_sl2[0]  = 8'(stwg_pkg::SL2_RESET); set_sr1[0] = 8'(stwg_pkg::SR1_RESET);
    set_pos1[1] = 8'd0;   set_sl1[1] = 8'd0;  set_sl2[1] = 8'd0;  set_sr1[1] = 8'd0;
    set_pos1[2] = 8'd155; set_sl1[2] = 8'd31; set_sl2[2] = 8'd31; set_sr1[2] = 8'd31;
    set_pos1[3] = 8'd255; set_sl1[3] = 8'd1;  set_sl2[3] = 8'd30; set_sr1[3] = 8'd16;
    set_pos1[4] = 8'd156; set_sl1[4] = 8'd31; set_sl2[4] = 8'd0;  set_sr1[4] = 8'd1;
    for (int p = 5; p < 7; p++) begin
      set_pos1[p] = 8'($urandom_range(255));
      set_sl1[p]  = 8'($urandom_range(255));
      set_sl2[p]  = 8'($urandom_range(255));
      set_sr1[p]  = 8'($urandom_range(255));
    end
    set_pos1[7] = stwg_pkg::POS1_RESET; set_sl1[7] = 8'(stwg_pkg::SL1_RESET);
    set_sl2[7]  = 8'(stwg_pkg::SL2_RESET); set_sr1[7] = 8'(stwg_pkg::SR1_RESET);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part with reset settings. Draws before any seed read the all-zero ring. Then
    // seeds at the extremes and a few ordinary ones, each followed by draws, so that the
    // regeneration runs at once; the ignored seed field of a draw swings between extremes.
    queue_item(stwg_pkg::KIND_DRAW, '0);
    queue_item(stwg_pkg::KIND_DRAW, '1);
    queue_item(stwg_pkg::KIND_DRAW, '0);
    queue_item(stwg_pkg::KIND_SEED, '0);
    queue_item(stwg_pkg::KIND_DRAW, '1);
    queue_item(stwg_pkg::KIND_DRAW, '0);
    queue_item(stwg_pkg::KIND_SEED, '1);
    queue_item(stwg_pkg::KIND_DRAW, '0);
    queue_item(stwg_pkg::KIND_DRAW, '1);
    queue_item(stwg_pkg::KIND_DRAW, '0);
    queue_item(stwg_pkg::KIND_SEED, 32'h8000_0000);
    queue_item(stwg_pkg::KIND_DRAW, '1);
    queue_item(stwg_pkg::KIND_SEED, 32'h0000_0001);
    queue_item(stwg_pkg::KIND_DRAW, '0);
    queue_item(stwg_pkg::KIND_SEED, $urandom);
    for (int i = 0; i < 4; i++) begin
      queue_item(stwg_pkg::KIND_DRAW, $urandom);
    end
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(stwg_pkg::REG_POS1, set_pos1[p]);
      write_reg(stwg_pkg::REG_SL1,  set_sl1[p]);
      write_reg(stwg_pkg::REG_SL2,  set_sl2[p]);
      write_reg(stwg_pkg::REG_SR1,  set_sr1[p]);
      @(posedge clk);
      idle_mode <= idle_mode_t'(p % 4);
      // In the phase where both sides idle, the receiver also holds off for a long stretch.
      if (p == 3) begin
        hold_requests <= hold_requests + 1;
      end
      if (p == 0) begin
        // One seed followed by a run long enough to read every lane and wrap into a second
        // regeneration, which then works on an already regenerated ring.
        queue_item(stwg_pkg::KIND_SEED, $urandom);
        for (int i = 0; i < LONG_RUN; i++) begin
          queue_item(stwg_pkg::KIND_DRAW, $urandom);
        end
      end else begin
        queue_phase(PHASE_ITEMS);
      end
      // The sender pauses here until every owed lane has come back.
      wait_quiet();
    end

    if (mismatch_count == 0 && lane_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
